// File: design/breakpoint_address_set_assert.svh
// ----------------------------------------------------------------------------
// Breakpoint address set assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ADDRESS_SET_ASSERT_SVH
`define BREAKPOINT_ADDRESS_SET_ASSERT_SVH

// Same-cycle implication, masked while reset is applied.
`define BAS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is applied.
`define BAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays live through reset.
`define BAS_ASSERT_RESET(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg
// Request and result types and codes for the breakpoint address set.
// ----------------------------------------------------------------------------
package bas_pkg;

  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
  } out_item_t;

endpackage

// File: design/bas_in_stage.sv
// ----------------------------------------------------------------------------
// bas_in_stage
// Input register for one request; stalls only when the result side is full.
// ----------------------------------------------------------------------------
module bas_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  bas_pkg::in_item_t in_data,
  output logic             in_stall,
  input  logic             advance,
  output logic             vld,
  output bas_pkg::in_item_t item
);

  logic              vld_r;
  bas_pkg::in_item_t item_r;
  logic              take;

  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// File: design/bas_cam.sv
// ----------------------------------------------------------------------------
// bas_cam
// Address store with parallel match, packed from index 0; remove swaps in last.
// ----------------------------------------------------------------------------
module bas_cam #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  bas_pkg::in_item_t  item,
  output bas_pkg::out_item_t result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [bas_pkg::ADDR_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;

  logic [CAPACITY-1:0]        hit;
  logic                       present;
  logic                       full;
  logic [CW-1:0]              last_cnt;
  logic [IW-1:0]              last_idx;
  logic [IW-1:0]              add_idx;
  logic [bas_pkg::ADDR_W-1:0] last_entry;
  logic                       do_add;
  logic                       do_remove;
  logic [1:0]                 status;
  logic [CW+bas_pkg::COUNT_W-1:0] count_ext;

  // only live entries take part in the match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (CW'(i) < count_r) && (entries_r[i] == item.address);
    end
  end

  assign present    = |hit;
  assign full       = (count_r == CW'(CAPACITY));
  assign last_cnt   = count_r - CW'(1);
  assign last_idx   = last_cnt[IW-1:0];
  assign add_idx    = count_r[IW-1:0];
  assign last_entry = entries_r[last_idx];

  always_comb begin
    do_add    = 1'b0;
    do_remove = 1'b0;
    status    = bas_pkg::ST_DONE;
    count_nxt = count_r;
    unique case (item.operation)
      bas_pkg::OP_ADD: begin
        if (present) begin
          status = bas_pkg::ST_NOCHANGE;
        end else if (full) begin
          status = bas_pkg::ST_FULL;
        end else begin
          do_add    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      bas_pkg::OP_REMOVE: begin
        if (!present) begin
          status = bas_pkg::ST_NOCHANGE;
        end else begin
          do_remove = 1'b1;
          count_nxt = last_cnt;
        end
      end
      default: begin
        // query, and the unused code behaves as one
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // remove fills the hole with the last live entry
  always_ff @(posedge clk) begin
    if (fire) begin
      if (do_add) begin
        entries_r[add_idx] <= item.address;
      end
      if (do_remove) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (hit[i]) begin
            entries_r[i] <= last_entry;
          end
        end
      end
    end
  end

  assign count_ext          = {{bas_pkg::COUNT_W{1'b0}}, count_nxt};
  assign result.was_present = present;
  assign result.entry_count = count_ext[bas_pkg::COUNT_W-1:0];
  assign result.status      = status;

endmodule

// File: design/bas_out_stage.sv
// ----------------------------------------------------------------------------
// bas_out_stage
// Result register; takes a new result when empty or being drained.
// ----------------------------------------------------------------------------
module bas_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bas_pkg::out_item_t result,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output bas_pkg::out_item_t out_data
);

  logic               vld_r;
  bas_pkg::out_item_t data_r;

  assign room = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (room) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// File: design/breakpoint_address_set.sv
// ----------------------------------------------------------------------------
// breakpoint_address_set - set of up to CAPACITY distinct 16-bit addresses
// Path: accepted request -> input register -> result register -> out_valid.
// Throughput: one request per cycle while out_stall is low; combinational match.
// Reset: synchronous active-low rst_n empties the set; entry storage not cleared.
// ----------------------------------------------------------------------------
module breakpoint_address_set #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bas_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bas_pkg::out_item_t out_data
);

  // Datapath:
  //   in_stage : registers the accepted request
  //   cam      : compares the address against every live entry, decides the
  //              operation and writes the store and count in the same edge
  //              that the result is captured
  //   out_stage: holds the result until the consumer takes it
  // Each request sees the store as left by the one before, so no forwarding
  // is needed.

  logic               stage_vld;
  bas_pkg::in_item_t  stage_item;
  logic               room;
  logic               fire;
  bas_pkg::out_item_t result;

  // a request is processed when the result register can take it
  assign fire = stage_vld && room;

  bas_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (room),
    .vld      (stage_vld),
    .item     (stage_item)
  );

  bas_cam #(
    .CAPACITY (CAPACITY)
  ) u_cam (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (stage_item),
    .result (result)
  );

  bas_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/bas_checker.sv
// ----------------------------------------------------------------------------
// bas_checker
// Port-level checks for the breakpoint address set, bound to the top level.
// ----------------------------------------------------------------------------
`include "breakpoint_address_set_assert.svh"

module bas_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bas_pkg::out_item_t out_data
);

  localparam logic [bas_pkg::COUNT_W-1:0] CapMask = bas_pkg::COUNT_W'(CAPACITY);

  // held result stays put
  `BAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // input side only backs up when the result side is full and stalled
  `BAS_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_valid && in_stall, out_valid && out_stall, "input stalled without a full result stage")

  // a dropped add means absent address and a full set
  `BAS_ASSERT_IMPL(a_full_drop, clk, rst_n, out_valid && (out_data.status == bas_pkg::ST_FULL), !out_data.was_present && (out_data.entry_count == CapMask), "full drop with wrong presence or count")

  `BAS_ASSERT_RESET(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind breakpoint_address_set bas_checker #(
  .CAPACITY (CAPACITY)
) u_bas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
